@@ sv/lrst_pkg.sv @@
// Shared types and constants for the lazy range-add / range-sum tree.
// No dependencies; used by the top level and lrst_seq (lrst_ram does not use it).
`timescale 1ns / 1ps

package lrst_pkg;

    localparam int POS_W  = 11;
    localparam int DATA_W = 64;
    localparam int ADD_W  = 32;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_SUM = 1'b1;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_WT,
        ST_MUL,
        ST_WSUM,
        ST_CH0,
        ST_CH1,
        ST_CH2,
        ST_DEC,
        ST_RET,
        ST_CMB0,
        ST_CMB1,
        ST_CMB2
    } seq_state_t;

endpackage

@@ sv/lazy_range_add_sum_tree_top.sv @@
// Top level of the lazy range-add / range-sum tree.
// Depends on lrst_pkg, lrst_ram and lrst_seq.
`timescale 1ns / 1ps
//
// Command channel: an item (cmd, range_low, range_high, add_value) is taken
// on a clock edge with start high and busy low. cmd 0 adds add_value to each
// position in the interval and returns nothing; cmd 1 returns the interval
// sum on range_sum for one cycle with result_valid high. The receiver cannot
// stall; each result is shown exactly once.
// Config channel: cfg_data is written to size_reg on an edge with
// cfg_valid and cfg_ready high; cfg_ready is always high. Write it idle only.
// Steps: each node RAM has one read port. A visited node is read (ST_RD,
// ST_WT) and decided (ST_DEC); a pending add is first settled (ST_MUL,
// ST_WSUM) and pushed to the children (ST_CH0 to ST_CH2, not at a leaf),
// and the node returns through ST_RET. A fully covered node of a range add
// applies the add through the same settle and push steps, and each parent
// of a range add recombines its children (ST_CMB0 to ST_CMB2) on the way
// back. A root outside the interval goes from ST_DEC to ST_RET. busy drops
// the cycle the result is shown. An empty interval (low above high) keeps
// busy low; a query on it shows 0 the next cycle.
// Reset: after rst_n releases, both RAMs are cleared one entry per cycle,
// all 4*LEAVES entries (4096 at default), with busy high.

module lazy_range_add_sum_tree_top #(
    parameter int LEAVES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic [lrst_pkg::POS_W-1:0]        range_low,
    input  logic [lrst_pkg::POS_W-1:0]        range_high,
    input  logic signed [lrst_pkg::ADD_W-1:0] add_value,
    output logic                              result_valid,
    output logic signed [lrst_pkg::DATA_W-1:0] range_sum,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lrst_pkg::POS_W-1:0]        cfg_data
);

    localparam int NODES = 4 * LEAVES;
    localparam int ID_W  = $clog2(NODES);
    localparam int DW    = lrst_pkg::DATA_W;
    localparam int PW    = lrst_pkg::POS_W;

    logic [PW-1:0]   size_reg, size_next;
    logic [PW-1:0]   size_eff;
    logic [DW-1:0]   sum_out;

    logic            sum_we, pend_we;
    logic [ID_W-1:0] sum_waddr, sum_raddr, pend_waddr, pend_raddr;
    logic [DW-1:0]   sum_wdata, sum_rdata, pend_wdata, pend_rdata;

    assign cfg_ready = 1'b1;
    assign size_next = (cfg_valid && cfg_ready) ? cfg_data : size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= PW'(1024);
        end
        else
        begin
            size_reg <= size_next;
        end
    end

    always_comb
    begin
        if (size_reg == '0)
        begin
            size_eff = PW'(1);
        end
        else if (32'(size_reg) > 32'(LEAVES))
        begin
            size_eff = PW'(LEAVES);
        end
        else
        begin
            size_eff = size_reg;
        end
    end

    assign range_sum = sum_out;

    lrst_ram #(.WIDTH(DW), .DEPTH(NODES)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    lrst_ram #(.WIDTH(DW), .DEPTH(NODES)) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (pend_wdata),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

    lrst_seq #(.LEAVES(LEAVES)) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .range_low    (range_low),
        .range_high   (range_high),
        .add_value    (add_value),
        .size_eff     (size_eff),
        .busy         (busy),
        .result_valid (result_valid),
        .range_sum    (sum_out),
        .sum_we       (sum_we),
        .sum_waddr    (sum_waddr),
        .sum_wdata    (sum_wdata),
        .sum_raddr    (sum_raddr),
        .sum_rdata    (sum_rdata),
        .pend_we      (pend_we),
        .pend_waddr   (pend_waddr),
        .pend_wdata   (pend_wdata),
        .pend_raddr   (pend_raddr),
        .pend_rdata   (pend_rdata)
    );

endmodule

@@ sv/lrst_ram.sv @@
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lrst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ sv/lrst_seq.sv @@
// Tree walk sequencer: explicit ancestor stack, settle / push-down and
// recombine steps over the node sum and pending-add RAMs. Uses lrst_pkg.
`timescale 1ns / 1ps

module lrst_seq #(
    parameter int LEAVES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              cmd,
    input  logic [lrst_pkg::POS_W-1:0]        range_low,
    input  logic [lrst_pkg::POS_W-1:0]        range_high,
    input  logic signed [lrst_pkg::ADD_W-1:0] add_value,
    input  logic [lrst_pkg::POS_W-1:0]        size_eff,
    output logic                              busy,
    output logic                              result_valid,
    output logic [lrst_pkg::DATA_W-1:0]       range_sum,
    output logic                              sum_we,
    output logic [$clog2(4*LEAVES)-1:0]       sum_waddr,
    output logic [lrst_pkg::DATA_W-1:0]       sum_wdata,
    output logic [$clog2(4*LEAVES)-1:0]       sum_raddr,
    input  logic [lrst_pkg::DATA_W-1:0]       sum_rdata,
    output logic                              pend_we,
    output logic [$clog2(4*LEAVES)-1:0]       pend_waddr,
    output logic [lrst_pkg::DATA_W-1:0]       pend_wdata,
    output logic [$clog2(4*LEAVES)-1:0]       pend_raddr,
    input  logic [lrst_pkg::DATA_W-1:0]       pend_rdata
);

    localparam int ID_W  = $clog2(4*LEAVES);
    localparam int DEPTH = $clog2(LEAVES) + 1;
    localparam int SP_W  = $clog2(DEPTH + 1);
    localparam int IX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = lrst_pkg::POS_W;
    localparam int DW    = lrst_pkg::DATA_W;

    lrst_pkg::seq_state_t state_reg, state_next;

    logic [ID_W-1:0] clr_reg, clr_next;
    logic [ID_W-1:0] cur_id_reg, cur_id_next;
    logic [PW-1:0]   cur_lo_reg, cur_lo_next;
    logic [PW-1:0]   cur_hi_reg, cur_hi_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic            cmd_reg, cmd_next;
    logic [PW-1:0]   a_reg, a_next;
    logic [PW-1:0]   b_reg, b_next;
    logic [DW-1:0]   amt_reg, amt_next;
    logic [DW-1:0]   acc_reg, acc_next;
    logic [DW-1:0]   sum_reg, sum_next;
    logic [DW-1:0]   p_reg, p_next;
    logic [DW-1:0]   left_reg, left_next;
    logic [42:0]     prod_lo_reg, prod_lo_next;
    logic [31:0]     prod_hi_reg, prod_hi_next;
    logic            apply_reg, apply_next;
    logic            res_valid_reg, res_valid_next;
    logic [DW-1:0]   res_reg, res_next;

    logic [ID_W-1:0] stk_id_reg [DEPTH];
    logic [PW-1:0]   stk_lo_reg [DEPTH];
    logic [PW-1:0]   stk_hi_reg [DEPTH];
    logic            stk_rd_reg [DEPTH];

    logic            stk_push, stk_mark;
    logic [IX_W-1:0] push_ix, top_ix;

    logic [PW-1:0]   len, mid, p_mid;
    logic [PW:0]     mid_sum, p_mid_sum;
    logic [ID_W-1:0] left_id, right_id, p_id, p_right;
    logic [PW-1:0]   p_lo, p_hi;
    logic            p_rd;
    logic [DW-1:0]   settled;
    logic            outside, covered;

    assign push_ix  = sp_reg[IX_W-1:0];
    assign top_ix   = IX_W'(sp_reg - SP_W'(1));
    assign len      = cur_hi_reg - cur_lo_reg + PW'(1);
    assign mid_sum  = {1'b0, cur_lo_reg} + {1'b0, cur_hi_reg};
    assign mid      = mid_sum[PW:1];
    assign left_id  = {cur_id_reg[ID_W-2:0], 1'b0};
    assign right_id = {cur_id_reg[ID_W-2:0], 1'b1};
    assign p_id     = stk_id_reg[top_ix];
    assign p_lo     = stk_lo_reg[top_ix];
    assign p_hi     = stk_hi_reg[top_ix];
    assign p_rd     = stk_rd_reg[top_ix];
    assign p_mid_sum = {1'b0, p_lo} + {1'b0, p_hi};
    assign p_mid    = p_mid_sum[PW:1];
    assign p_right  = {p_id[ID_W-2:0], 1'b1};
    assign settled  = sum_reg + DW'(prod_lo_reg) + {prod_hi_reg, 32'd0};
    assign outside  = (cur_lo_reg > b_reg) || (cur_hi_reg < a_reg);
    assign covered  = (a_reg <= cur_lo_reg) && (cur_hi_reg <= b_reg);

    assign busy         = (state_reg != lrst_pkg::ST_IDLE);
    assign result_valid = res_valid_reg;
    assign range_sum    = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_id_next    = cur_id_reg;
        cur_lo_next    = cur_lo_reg;
        cur_hi_next    = cur_hi_reg;
        sp_next        = sp_reg;
        cmd_next       = cmd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        amt_next       = amt_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        p_next         = p_reg;
        left_next      = left_reg;
        prod_lo_next   = 43'(p_reg[31:0]) * 43'(len);
        prod_hi_next   = p_reg[63:32] * 32'(len);
        apply_next     = apply_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        stk_push       = 1'b0;
        stk_mark       = 1'b0;
        sum_we         = 1'b0;
        sum_waddr      = cur_id_reg;
        sum_wdata      = settled;
        sum_raddr      = cur_id_reg;
        pend_we        = 1'b0;
        pend_waddr     = cur_id_reg;
        pend_wdata     = '0;
        pend_raddr     = cur_id_reg;

        case (state_reg)
            lrst_pkg::ST_CLR:
            begin
                sum_we     = 1'b1;
                sum_waddr  = clr_reg;
                sum_wdata  = '0;
                pend_we    = 1'b1;
                pend_waddr = clr_reg;
                clr_next   = clr_reg + ID_W'(1);
                if (&clr_reg)
                begin
                    state_next = lrst_pkg::ST_IDLE;
                end
            end
            lrst_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    a_next      = range_low;
                    b_next      = range_high;
                    amt_next    = DW'(add_value);
                    acc_next    = '0;
                    cur_id_next = ID_W'(1);
                    cur_lo_next = PW'(1);
                    cur_hi_next = size_eff;
                    sp_next     = '0;
                    apply_next  = 1'b0;
                    if (range_low > range_high)
                    begin
                        res_valid_next = (cmd == lrst_pkg::CMD_SUM);
                        res_next       = '0;
                    end
                    else
                    begin
                        state_next = lrst_pkg::ST_RD;
                    end
                end
            end
            lrst_pkg::ST_RD:
            begin
                state_next = lrst_pkg::ST_WT;
            end
            lrst_pkg::ST_WT:
            begin
                sum_next   = sum_rdata;
                p_next     = pend_rdata;
                apply_next = 1'b0;
                state_next = (pend_rdata == '0) ? lrst_pkg::ST_DEC : lrst_pkg::ST_MUL;
            end
            lrst_pkg::ST_MUL:
            begin
                state_next = lrst_pkg::ST_WSUM;
            end
            lrst_pkg::ST_WSUM:
            begin
                sum_we   = 1'b1;
                pend_we  = 1'b1;
                sum_next = settled;
                if (cur_lo_reg != cur_hi_reg)
                begin
                    state_next = lrst_pkg::ST_CH0;
                end
                else
                begin
                    state_next = apply_reg ? lrst_pkg::ST_RET : lrst_pkg::ST_DEC;
                end
            end
            lrst_pkg::ST_CH0:
            begin
                pend_raddr = left_id;
                state_next = lrst_pkg::ST_CH1;
            end
            lrst_pkg::ST_CH1:
            begin
                pend_we    = 1'b1;
                pend_waddr = left_id;
                pend_wdata = pend_rdata + p_reg;
                pend_raddr = right_id;
                state_next = lrst_pkg::ST_CH2;
            end
            lrst_pkg::ST_CH2:
            begin
                pend_we    = 1'b1;
                pend_waddr = right_id;
                pend_wdata = pend_rdata + p_reg;
                state_next = apply_reg ? lrst_pkg::ST_RET : lrst_pkg::ST_DEC;
            end
            lrst_pkg::ST_DEC:
            begin
                if (outside)
                begin
                    state_next = lrst_pkg::ST_RET;
                end
                else if (covered)
                begin
                    if (cmd_reg == lrst_pkg::CMD_SUM)
                    begin
                        acc_next   = acc_reg + sum_reg;
                        state_next = lrst_pkg::ST_RET;
                    end
                    else if (amt_reg == '0)
                    begin
                        state_next = lrst_pkg::ST_RET;
                    end
                    else
                    begin
                        p_next     = amt_reg;
                        apply_next = 1'b1;
                        state_next = lrst_pkg::ST_MUL;
                    end
                end
                else
                begin
                    stk_push    = 1'b1;
                    sp_next     = sp_reg + SP_W'(1);
                    cur_id_next = left_id;
                    cur_hi_next = mid;
                    state_next  = lrst_pkg::ST_RD;
                end
            end
            lrst_pkg::ST_RET:
            begin
                if (sp_reg == '0)
                begin
                    res_valid_next = (cmd_reg == lrst_pkg::CMD_SUM);
                    res_next       = acc_reg;
                    state_next     = lrst_pkg::ST_IDLE;
                end
                else if (!p_rd)
                begin
                    stk_mark    = 1'b1;
                    cur_id_next = p_right;
                    cur_lo_next = p_mid + PW'(1);
                    cur_hi_next = p_hi;
                    state_next  = lrst_pkg::ST_RD;
                end
                else
                begin
                    cur_id_next = p_id;
                    cur_lo_next = p_lo;
                    cur_hi_next = p_hi;
                    sp_next     = sp_reg - SP_W'(1);
                    state_next  = (cmd_reg == lrst_pkg::CMD_ADD) ?
                                  lrst_pkg::ST_CMB0 : lrst_pkg::ST_RET;
                end
            end
            lrst_pkg::ST_CMB0:
            begin
                sum_raddr  = left_id;
                state_next = lrst_pkg::ST_CMB1;
            end
            lrst_pkg::ST_CMB1:
            begin
                sum_raddr  = right_id;
                left_next  = sum_rdata;
                state_next = lrst_pkg::ST_CMB2;
            end
            lrst_pkg::ST_CMB2:
            begin
                sum_we     = 1'b1;
                sum_wdata  = left_reg + sum_rdata;
                state_next = lrst_pkg::ST_RET;
            end
            default:
            begin
                state_next = lrst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrst_pkg::ST_CLR;
            clr_reg       <= '0;
            sp_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sp_reg        <= sp_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_id_reg  <= cur_id_next;
        cur_lo_reg  <= cur_lo_next;
        cur_hi_reg  <= cur_hi_next;
        cmd_reg     <= cmd_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        amt_reg     <= amt_next;
        acc_reg     <= acc_next;
        sum_reg     <= sum_next;
        p_reg       <= p_next;
        left_reg    <= left_next;
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        apply_reg   <= apply_next;
        res_reg     <= res_next;
        if (stk_push)
        begin
            stk_id_reg[push_ix] <= cur_id_reg;
            stk_lo_reg[push_ix] <= cur_lo_reg;
            stk_hi_reg[push_ix] <= cur_hi_reg;
            stk_rd_reg[push_ix] <= 1'b0;
        end
        if (stk_mark)
        begin
            stk_rd_reg[top_ix] <= 1'b1;
        end
    end

endmodule
